// ----- rtl/core/sbox_pkg.sv -----
// ----------------------------------------------------------------------------
// sbox_pkg: shared types and constants for the segment/box overlap unit
// widths of the doubled fixed-point quantities and the register map
// ----------------------------------------------------------------------------
package sbox_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // box size field is one bit narrower than a coordinate
  localparam int SIZE_BITS  = COORD_BITS - 1;
  // d = end - start
  localparam int DIFF_BITS  = COORD_BITS + 1;
  // m = start + end - 2*(offset + corner) - size
  localparam int MID_BITS   = COORD_BITS + 3;
  localparam int MAG_M_BITS = COORD_BITS + 2;
  localparam int MAG_D_BITS = COORD_BITS + 1;
  // |d| + eps
  localparam int DEPS_BITS  = COORD_BITS + 2;

  // |m| split in two halves for the cross products
  localparam int MLO_BITS   = MAG_M_BITS / 2;
  localparam int MHI_BITS   = MAG_M_BITS - MLO_BITS;
  localparam int PLO_BITS   = MLO_BITS + MAG_D_BITS;
  localparam int PHI_BITS   = MHI_BITS + MAG_D_BITS;
  localparam int PROD_BITS  = MAG_M_BITS + MAG_D_BITS;
  localparam int LHS_BITS   = PROD_BITS + 1;
  localparam int RPROD_BITS = SIZE_BITS + DEPS_BITS;
  localparam int RHS_BITS   = RPROD_BITS + 1;
  localparam int WSUM_BITS  = MAG_M_BITS + 1;

  // doubled epsilon 0.0002, rounded to the nearest lsb
  localparam int unsigned EPS2 = ((1 << FRAC_BITS) + 2500) / 5000;

  // input transaction to result strobe
  localparam int LATENCY    = 7;

  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]         size_t;
  typedef logic signed [MID_BITS-1:0]   mid_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2
  } reg_idx_e;

  // per-axis magnitudes and signs after the abs stage
  typedef struct packed {
    logic [MAG_M_BITS-1:0] m_mag;
    logic                  m_neg;
    logic [MAG_D_BITS-1:0] d_mag;
    logic                  d_neg;
    logic [SIZE_BITS-1:0]  e;
    logic [DEPS_BITS-1:0]  d_eps;
  } axis_t;

endpackage

// ----- rtl/core/sbox_prep.sv -----
// ----------------------------------------------------------------------------
// sbox_prep: doubled midpoint and direction per axis
// first pipeline stage, m = s + t - 2*(off + c) - e and d = t - s
// ----------------------------------------------------------------------------
module sbox_prep (
  input  logic              clk_i,
  input  sbox_pkg::coord_t  start_i  [3],
  input  sbox_pkg::coord_t  end_i    [3],
  input  sbox_pkg::coord_t  corner_i [3],
  input  sbox_pkg::size_t   size_i   [3],
  input  sbox_pkg::coord_t  offset_i [3],
  output sbox_pkg::mid_t    m_o      [3],
  output sbox_pkg::diff_t   d_o      [3],
  output sbox_pkg::size_t   e_o      [3]
);

  sbox_pkg::mid_t  m_d [3];
  sbox_pkg::diff_t d_d [3];
  sbox_pkg::mid_t  m_q [3];
  sbox_pkg::diff_t d_q [3];
  sbox_pkg::size_t e_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign d_d[i] = sbox_pkg::DIFF_BITS'(end_i[i]) - sbox_pkg::DIFF_BITS'(start_i[i]);
    assign m_d[i] = sbox_pkg::MID_BITS'(start_i[i]) + sbox_pkg::MID_BITS'(end_i[i])
                  - (sbox_pkg::MID_BITS'(offset_i[i]) <<< 1)
                  - (sbox_pkg::MID_BITS'(corner_i[i]) <<< 1)
                  - $signed({4'b0000, size_i[i]});

    always_ff @(posedge clk_i) begin
      m_q[i] <= m_d[i];
      d_q[i] <= d_d[i];
      e_q[i] <= size_i[i];
    end

    assign m_o[i] = m_q[i];
    assign d_o[i] = d_q[i];
    assign e_o[i] = e_q[i];
  end

endmodule

// ----- rtl/core/sbox_axis.sv -----
// ----------------------------------------------------------------------------
// sbox_axis: magnitudes, signs and the world-axis tests
// stage two takes absolute values, stage three compares |m| > e + |d|
// ----------------------------------------------------------------------------
module sbox_axis (
  input  logic              clk_i,
  input  sbox_pkg::mid_t    m_i [3],
  input  sbox_pkg::diff_t   d_i [3],
  input  sbox_pkg::size_t   e_i [3],
  output sbox_pkg::axis_t   axis_o [3],
  output logic [2:0]        world_sep_o
);

  sbox_pkg::axis_t axis_d [3];
  sbox_pkg::axis_t axis_q [3];
  logic [2:0]      sep_d;
  logic [2:0]      sep_q;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    sbox_pkg::mid_t  m_neg;
    sbox_pkg::diff_t d_neg;

    assign m_neg = -m_i[i];
    assign d_neg = -d_i[i];

    always_comb begin
      axis_d[i].m_neg = m_i[i][sbox_pkg::MID_BITS-1];
      axis_d[i].d_neg = d_i[i][sbox_pkg::DIFF_BITS-1];
      axis_d[i].m_mag = axis_d[i].m_neg ? m_neg[sbox_pkg::MAG_M_BITS-1:0]
                                        : m_i[i][sbox_pkg::MAG_M_BITS-1:0];
      axis_d[i].d_mag = axis_d[i].d_neg ? d_neg[sbox_pkg::MAG_D_BITS-1:0]
                                        : d_i[i][sbox_pkg::MAG_D_BITS-1:0];
      axis_d[i].e     = e_i[i];
      axis_d[i].d_eps = sbox_pkg::DEPS_BITS'(axis_d[i].d_mag)
                      + sbox_pkg::DEPS_BITS'(sbox_pkg::EPS2);
    end

    // separated along this world axis if |m| > e + |d|
    assign sep_d[i] = sbox_pkg::WSUM_BITS'(axis_q[i].m_mag)
                    > (sbox_pkg::WSUM_BITS'(axis_q[i].e)
                       + sbox_pkg::WSUM_BITS'(axis_q[i].d_mag));

    always_ff @(posedge clk_i) begin
      axis_q[i] <= axis_d[i];
      sep_q[i]  <= sep_d[i];
    end

    assign axis_o[i] = axis_q[i];
  end

  assign world_sep_o = sep_q;

endmodule

// ----- rtl/core/sbox_cross.sv -----
// ----------------------------------------------------------------------------
// sbox_cross: one cross-axis separation test
// |m_a*d_b - m_b*d_a| > e_a*(|d_b|+eps) + e_b*(|d_a|+eps), stages three to six
// ----------------------------------------------------------------------------
module sbox_cross (
  input  logic             clk_i,
  input  sbox_pkg::axis_t  a_i,
  input  sbox_pkg::axis_t  b_i,
  output logic             sep_o
);

  // stage three: partial products
  logic [sbox_pkg::PLO_BITS-1:0]   plo_a_q, plo_b_q;
  logic [sbox_pkg::PHI_BITS-1:0]   phi_a_q, phi_b_q;
  logic                            neg_a_q, neg_b_q;
  logic [sbox_pkg::RPROD_BITS-1:0] ra_q, rb_q;
  // stage four: full products
  logic [sbox_pkg::PROD_BITS-1:0]  pa_q, pb_q;
  logic                            same_q;
  logic [sbox_pkg::RHS_BITS-1:0]   rhs4_q;
  // stage five: magnitude of the difference
  logic [sbox_pkg::LHS_BITS-1:0]   lhs_q;
  logic [sbox_pkg::RHS_BITS-1:0]   rhs5_q;
  // stage six
  logic                            sep_q;

  logic [sbox_pkg::LHS_BITS-1:0]   sum_d, dab_d, dba_d, lhs_d;

  always_ff @(posedge clk_i) begin
    plo_a_q <= sbox_pkg::PLO_BITS'(a_i.m_mag[sbox_pkg::MLO_BITS-1:0])
             * sbox_pkg::PLO_BITS'(b_i.d_mag);
    phi_a_q <= sbox_pkg::PHI_BITS'(a_i.m_mag[sbox_pkg::MAG_M_BITS-1:sbox_pkg::MLO_BITS])
             * sbox_pkg::PHI_BITS'(b_i.d_mag);
    plo_b_q <= sbox_pkg::PLO_BITS'(b_i.m_mag[sbox_pkg::MLO_BITS-1:0])
             * sbox_pkg::PLO_BITS'(a_i.d_mag);
    phi_b_q <= sbox_pkg::PHI_BITS'(b_i.m_mag[sbox_pkg::MAG_M_BITS-1:sbox_pkg::MLO_BITS])
             * sbox_pkg::PHI_BITS'(a_i.d_mag);
    neg_a_q <= a_i.m_neg ^ b_i.d_neg;
    neg_b_q <= b_i.m_neg ^ a_i.d_neg;
    ra_q    <= sbox_pkg::RPROD_BITS'(a_i.e) * sbox_pkg::RPROD_BITS'(b_i.d_eps);
    rb_q    <= sbox_pkg::RPROD_BITS'(b_i.e) * sbox_pkg::RPROD_BITS'(a_i.d_eps);
  end

  always_ff @(posedge clk_i) begin
    pa_q   <= (sbox_pkg::PROD_BITS'(phi_a_q) << sbox_pkg::MLO_BITS)
            + sbox_pkg::PROD_BITS'(plo_a_q);
    pb_q   <= (sbox_pkg::PROD_BITS'(phi_b_q) << sbox_pkg::MLO_BITS)
            + sbox_pkg::PROD_BITS'(plo_b_q);
    same_q <= (neg_a_q == neg_b_q);
    rhs4_q <= sbox_pkg::RHS_BITS'(ra_q) + sbox_pkg::RHS_BITS'(rb_q);
  end

  // equal signs: |pa - pb|, opposite signs: pa + pb
  always_comb begin
    sum_d = sbox_pkg::LHS_BITS'(pa_q) + sbox_pkg::LHS_BITS'(pb_q);
    dab_d = sbox_pkg::LHS_BITS'(pa_q) - sbox_pkg::LHS_BITS'(pb_q);
    dba_d = sbox_pkg::LHS_BITS'(pb_q) - sbox_pkg::LHS_BITS'(pa_q);
    if (!same_q) begin
      lhs_d = sum_d;
    end else if (pa_q >= pb_q) begin
      lhs_d = dab_d;
    end else begin
      lhs_d = dba_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lhs_q  <= lhs_d;
    rhs5_q <= rhs4_q;
    sep_q  <= lhs_q > sbox_pkg::LHS_BITS'(rhs5_q);
  end

  assign sep_o = sep_q;

endmodule

// ----- rtl/core/segment_box_overlap_test_unit.sv -----
// ----------------------------------------------------------------------------
// segment_box_overlap_test_unit: segment versus axis-aligned box overlap
// each accepted start yields a done_o strobe at the end of the pipeline below
// throughput: one transaction per cycle, busy is never raised
// the receiver cannot stall; every result shows for exactly one cycle
// reset: rst_ni async low clears the offsets and the valid pipeline
// ----------------------------------------------------------------------------
module segment_box_overlap_test_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // apb-style configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sbox_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [sbox_pkg::DATA_BITS-1:0]       pwdata,
  output logic [sbox_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready,
  // command handshake
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sbox_pkg::COORD_BITS-1:0] seg_start_x_i,
  input  logic signed [sbox_pkg::COORD_BITS-1:0] seg_start_y_i,
  input  logic signed [sbox_pkg::COORD_BITS-1:0] seg_start_z_i,
  input  logic signed [sbox_pkg::COORD_BITS-1:0] seg_end_x_i,
  input  logic signed [sbox_pkg::COORD_BITS-1:0] seg_end_y_i,
  input  logic signed [sbox_pkg::COORD_BITS-1:0] seg_end_z_i,
  input  logic signed [sbox_pkg::COORD_BITS-1:0] box_corner_x_i,
  input  logic signed [sbox_pkg::COORD_BITS-1:0] box_corner_y_i,
  input  logic signed [sbox_pkg::COORD_BITS-1:0] box_corner_z_i,
  input  logic [sbox_pkg::SIZE_BITS-1:0]       box_size_x_i,
  input  logic [sbox_pkg::SIZE_BITS-1:0]       box_size_y_i,
  input  logic [sbox_pkg::SIZE_BITS-1:0]       box_size_z_i,
  // result strobe
  output logic                                 done_o,
  output logic                                 overlap_o
);

  // pipeline map
  //   stage 1  sbox_prep   doubled midpoint m and direction d
  //   stage 2  sbox_axis   magnitudes and signs, |d| + eps
  //   stage 3  sbox_axis   world-axis compares; sbox_cross partial products
  //   stage 4  sbox_cross  full products and rhs sum
  //   stage 5  sbox_cross  |m_a*d_b - m_b*d_a|
  //   stage 6  sbox_cross  cross-axis compare
  //   stage 7  here        combine all six tests into overlap

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  sbox_pkg::coord_t off_q [3];
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sbox_pkg::REG_OFFSET_X: off_q[0] <= pwdata;
        sbox_pkg::REG_OFFSET_Y: off_q[1] <= pwdata;
        sbox_pkg::REG_OFFSET_Z: off_q[2] <= pwdata;
        default: ;  // write to an unmapped address is dropped
      endcase
    end
  end

  // read mux, unmapped addresses read zero
  always_comb begin
    unique case (cfg_idx)
      sbox_pkg::REG_OFFSET_X: prdata = off_q[0];
      sbox_pkg::REG_OFFSET_Y: prdata = off_q[1];
      sbox_pkg::REG_OFFSET_Z: prdata = off_q[2];
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // valid pipeline, one bit per stage travels beside the data
  // ---------------------------------------------------------------------------
  logic                          accept;
  logic [sbox_pkg::LATENCY-1:0]  vld_d;
  logic [sbox_pkg::LATENCY-1:0]  vld_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign vld_d  = {vld_q[sbox_pkg::LATENCY-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  sbox_pkg::coord_t seg_start  [3];
  sbox_pkg::coord_t seg_end    [3];
  sbox_pkg::coord_t box_corner [3];
  sbox_pkg::size_t  box_size   [3];

  assign seg_start[0]  = seg_start_x_i;
  assign seg_start[1]  = seg_start_y_i;
  assign seg_start[2]  = seg_start_z_i;
  assign seg_end[0]    = seg_end_x_i;
  assign seg_end[1]    = seg_end_y_i;
  assign seg_end[2]    = seg_end_z_i;
  assign box_corner[0] = box_corner_x_i;
  assign box_corner[1] = box_corner_y_i;
  assign box_corner[2] = box_corner_z_i;
  assign box_size[0]   = box_size_x_i;
  assign box_size[1]   = box_size_y_i;
  assign box_size[2]   = box_size_z_i;

  sbox_pkg::mid_t  mid  [3];
  sbox_pkg::diff_t dir  [3];
  sbox_pkg::size_t ext  [3];
  sbox_pkg::axis_t axis [3];
  logic [2:0]      world_sep;
  logic [2:0]      cross_sep;

  sbox_prep u_prep (
    .clk_i    (clk_i),
    .start_i  (seg_start),
    .end_i    (seg_end),
    .corner_i (box_corner),
    .size_i   (box_size),
    .offset_i (off_q),
    .m_o      (mid),
    .d_o      (dir),
    .e_o      (ext)
  );

  sbox_axis u_axis (
    .clk_i       (clk_i),
    .m_i         (mid),
    .d_i         (dir),
    .e_i         (ext),
    .axis_o      (axis),
    .world_sep_o (world_sep)
  );

  // cross axes in test order: d x x (y,z), d x y (x,z), d x z (x,y)
  sbox_cross u_cross_yz (
    .clk_i (clk_i),
    .a_i   (axis[1]),
    .b_i   (axis[2]),
    .sep_o (cross_sep[0])
  );

  sbox_cross u_cross_xz (
    .clk_i (clk_i),
    .a_i   (axis[0]),
    .b_i   (axis[2]),
    .sep_o (cross_sep[1])
  );

  sbox_cross u_cross_xy (
    .clk_i (clk_i),
    .a_i   (axis[0]),
    .b_i   (axis[1]),
    .sep_o (cross_sep[2])
  );

  // world-axis flags are ready at stage 3, hold them until stage 6
  logic [2:0] wdly_q [3];

  always_ff @(posedge clk_i) begin
    wdly_q[0] <= world_sep;
    wdly_q[1] <= wdly_q[0];
    wdly_q[2] <= wdly_q[1];
  end

  // overlap only when none of the six axes separates
  logic overlap_d;
  logic overlap_q;

  assign overlap_d = !((|wdly_q[2]) || (|cross_sep));

  always_ff @(posedge clk_i) begin
    overlap_q <= overlap_d;
  end

  assign done_o    = vld_q[sbox_pkg::LATENCY-1];
  assign overlap_o = overlap_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##7 done_o)
    else $error("result strobe missing seven cycles after a transaction");

  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 7))
    else $error("result strobe without a matching transaction");

  a_offset_x_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (cfg_idx == sbox_pkg::REG_OFFSET_X)) |=> (off_q[0] == $past(pwdata)))
    else $error("offset_x did not take the written value");

endmodule

// ----- sim/sbox_overlap_checker.sv -----
// ----------------------------------------------------------------------------
// sbox_overlap_checker: result checker for the segment/box overlap unit
// mirrors the offset registers, predicts the overlap flag of each accepted
// transaction with exact wide arithmetic and compares it with the strobe
// ----------------------------------------------------------------------------
module sbox_overlap_checker
  import sbox_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [ADDR_BITS-1:0] paddr_i,
  input  logic [DATA_BITS-1:0] pwdata_i,
  input  logic [DATA_BITS-1:0] prdata_i,
  input  logic                 pready_i,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  coord_t               seg_start_x_i,
  input  coord_t               seg_start_y_i,
  input  coord_t               seg_start_z_i,
  input  coord_t               seg_end_x_i,
  input  coord_t               seg_end_y_i,
  input  coord_t               seg_end_z_i,
  input  coord_t               box_corner_x_i,
  input  coord_t               box_corner_y_i,
  input  coord_t               box_corner_z_i,
  input  size_t                box_size_x_i,
  input  size_t                box_size_y_i,
  input  size_t                box_size_z_i,
  input  logic                 done_i,
  input  logic                 overlap_i,
  output int                   mismatches_o,
  output int                   outstanding_o,
  output int                   results_o,
  output int                   touches_o
);

  // doubled epsilon, rounded to the nearest lsb
  localparam longint EPS_LSB = ((longint'(1) << FRAC_BITS) + 2500) / 5000;

  typedef logic signed [127:0] prod_t;

  typedef struct packed {
    int unsigned tag;
    logic        touch;
  } verdict_t;

  coord_t      offset_x, offset_y, offset_z;
  verdict_t    verdict_q[$];
  int unsigned probe_tag;
  int          fails, seen, touched;

  function automatic longint mag_of(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // cross axis of the pair (a,b): |ma*db - mb*da| against the widened extents
  function automatic bit cross_separates(input longint ma, mb, da, db, ea, eb);
    prod_t lhs, rhs;
    lhs = prod_t'(ma) * prod_t'(db) - prod_t'(mb) * prod_t'(da);
    if (lhs < 0) lhs = -lhs;
    rhs = prod_t'(ea) * prod_t'(mag_of(db) + EPS_LSB)
        + prod_t'(eb) * prod_t'(mag_of(da) + EPS_LSB);
    return lhs > rhs;
  endfunction

  function automatic bit predict_touch(input coord_t sx, sy, sz, ex, ey, ez,
                                       cx, cy, cz, input size_t wx, wy, wz);
    longint s[3], t[3], c[3], o[3], m[3], d[3], e[3];
    s = '{longint'(sx), longint'(sy), longint'(sz)};
    t = '{longint'(ex), longint'(ey), longint'(ez)};
    c = '{longint'(cx), longint'(cy), longint'(cz)};
    o = '{longint'(offset_x), longint'(offset_y), longint'(offset_z)};
    e = '{longint'(wx), longint'(wy), longint'(wz)};
    // doubled midpoint distance and doubled half vector per axis
    for (int i = 0; i < 3; i++) begin
      d[i] = t[i] - s[i];
      m[i] = s[i] + t[i] - 2 * (o[i] + c[i]) - e[i];
    end
    for (int i = 0; i < 3; i++) begin
      if (mag_of(m[i]) > e[i] + mag_of(d[i])) return 1'b0;
    end
    if (cross_separates(m[1], m[2], d[1], d[2], e[1], e[2])) return 1'b0;
    if (cross_separates(m[0], m[2], d[0], d[2], e[0], e[2])) return 1'b0;
    if (cross_separates(m[0], m[1], d[0], d[1], e[0], e[1])) return 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    fails++;
    $display("%m: mismatch: %s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t head;
    if (!rst_ni) begin
      offset_x = '0;
      offset_y = '0;
      offset_z = '0;
      verdict_q.delete();
      probe_tag = 0;
      fails = 0;
      seen = 0;
      touched = 0;
      mismatches_o <= 0;
      outstanding_o <= 0;
      results_o <= 0;
      touches_o <= 0;
    end else begin
      // results first: the latency keeps them apart from this edge's input
      if (done_i) begin
        seen++;
        if (overlap_i === 1'b1) touched++;
        if (verdict_q.size() == 0) begin
          report_mismatch("result strobe with no transaction outstanding");
        end else begin
          head = verdict_q.pop_front();
          if (overlap_i !== head.touch)
            report_mismatch($sformatf("transaction %0d: overlap %b, expected %b",
                                      head.tag, overlap_i, head.touch));
        end
      end
      if (start_i && !busy_i) begin
        verdict_q.push_back('{tag: probe_tag,
                              touch: predict_touch(seg_start_x_i, seg_start_y_i,
                                                   seg_start_z_i, seg_end_x_i,
                                                   seg_end_y_i, seg_end_z_i,
                                                   box_corner_x_i, box_corner_y_i,
                                                   box_corner_z_i, box_size_x_i,
                                                   box_size_y_i, box_size_z_i)});
        probe_tag++;
      end
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (reg_idx_e'(paddr_i[ADDR_BITS-1:2]))
            REG_OFFSET_X: offset_x = pwdata_i;
            REG_OFFSET_Y: offset_y = pwdata_i;
            REG_OFFSET_Z: offset_z = pwdata_i;
            default: ;
          endcase
        end else begin
          case (reg_idx_e'(paddr_i[ADDR_BITS-1:2]))
            REG_OFFSET_X: if (prdata_i !== offset_x)
              report_mismatch($sformatf("offset_x read %h, expected %h", prdata_i, offset_x));
            REG_OFFSET_Y: if (prdata_i !== offset_y)
              report_mismatch($sformatf("offset_y read %h, expected %h", prdata_i, offset_y));
            REG_OFFSET_Z: if (prdata_i !== offset_z)
              report_mismatch($sformatf("offset_z read %h, expected %h", prdata_i, offset_z));
            default: ;
          endcase
        end
      end
      mismatches_o <= fails;
      outstanding_o <= verdict_q.size();
      results_o <= seen;
      touches_o <= touched;
    end
  end

endmodule

// ----- sim/tb_segment_box_overlap_test_unit.sv -----
// ----------------------------------------------------------------------------
// tb_segment_box_overlap_test_unit: testbench for the segment/box overlap unit
// drives a directed set of segment/box pairs and then random ones under
// several offset settings over the register port; a checker beside the
// block predicts every overlap flag and counts mismatches
// ----------------------------------------------------------------------------
module tb_segment_box_overlap_test_unit;
  import sbox_pkg::*;

  localparam int         QUIET_LIMIT  = 2000;   // cycles with no accepted transaction, result or bus access
  localparam int         PHASE_PROBES = 105;    // random transactions per offset setting
  localparam int         NUM_SETTINGS = 6;
  localparam longint     ONE          = 65536;  // 1.0 in Q16.16
  localparam longint     HALF         = 32768;
  localparam longint     COORD_MAX    = 2147483647;
  localparam longint     COORD_MIN    = -COORD_MAX - 1;
  localparam longint     SIZE_MAX     = 2147483647;
  localparam longint     PAST_DIAG    = 144179; // 2.2, just outside the unit box diagonal
  localparam longint     NEAR_DIAG    = 117965; // 1.8, cuts the unit box corner
  localparam logic [1:0] REG_SPARE    = 2'd3;   // index with no register behind it

  typedef struct packed {
    coord_t sx, sy, sz;
    coord_t ex, ey, ez;
    coord_t cx, cy, cz;
    size_t  wx, wy, wz;
  } probe_t;

  // clock, reset and block inputs, all known from time zero
  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [ADDR_BITS-1:0] paddr   = '0;
  logic [DATA_BITS-1:0] pwdata  = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 start   = 1'b0;
  logic                 busy;
  coord_t               seg_start_x = '0, seg_start_y = '0, seg_start_z = '0;
  coord_t               seg_end_x = '0, seg_end_y = '0, seg_end_z = '0;
  coord_t               box_corner_x = '0, box_corner_y = '0, box_corner_z = '0;
  size_t                box_size_x = '0, box_size_y = '0, box_size_z = '0;
  logic                 done_o;
  logic                 overlap_o;

  // checker status
  int mismatches, outstanding, results, touches;

  // sender bookkeeping
  int     sent;
  int     quiet_cycles;
  bit     steady;             // no idle cycles while set
  longint offset_shadow[3];   // current offsets, only used to aim boxes

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  segment_box_overlap_test_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .seg_start_x_i  (seg_start_x),
    .seg_start_y_i  (seg_start_y),
    .seg_start_z_i  (seg_start_z),
    .seg_end_x_i    (seg_end_x),
    .seg_end_y_i    (seg_end_y),
    .seg_end_z_i    (seg_end_z),
    .box_corner_x_i (box_corner_x),
    .box_corner_y_i (box_corner_y),
    .box_corner_z_i (box_corner_z),
    .box_size_x_i   (box_size_x),
    .box_size_y_i   (box_size_y),
    .box_size_z_i   (box_size_z),
    .done_o         (done_o),
    .overlap_o      (overlap_o)
  );

  sbox_overlap_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .start_i        (start),
    .busy_i         (busy),
    .seg_start_x_i  (seg_start_x),
    .seg_start_y_i  (seg_start_y),
    .seg_start_z_i  (seg_start_z),
    .seg_end_x_i    (seg_end_x),
    .seg_end_y_i    (seg_end_y),
    .seg_end_z_i    (seg_end_z),
    .box_corner_x_i (box_corner_x),
    .box_corner_y_i (box_corner_y),
    .box_corner_z_i (box_corner_z),
    .box_size_x_i   (box_size_x),
    .box_size_y_i   (box_size_y),
    .box_size_z_i   (box_size_z),
    .done_i         (done_o),
    .overlap_i      (overlap_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .results_o      (results),
    .touches_o      (touches)
  );

  // watchdog: the run is stuck once nothing has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_segment_box_overlap_test_unit: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // saturate an aimed coordinate into the field range
  function automatic coord_t clamp_coord(input longint v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  // signed value in [-2^k, 2^k]
  function automatic longint spread(input int k);
    return longint'($urandom_range(0, 32'd2 << k)) - (longint'(1) << k);
  endfunction

  function automatic probe_t probe_of(input longint sx, sy, sz, ex, ey, ez,
                                      cx, cy, cz, wx, wy, wz);
    probe_t p;
    p.sx = clamp_coord(sx); p.sy = clamp_coord(sy); p.sz = clamp_coord(sz);
    p.ex = clamp_coord(ex); p.ey = clamp_coord(ey); p.ez = clamp_coord(ez);
    p.cx = clamp_coord(cx); p.cy = clamp_coord(cy); p.cz = clamp_coord(cz);
    p.wx = size_t'(wx);     p.wy = size_t'(wy);     p.wz = size_t'(wz);
    return p;
  endfunction

  // every bit of every field at random
  function automatic probe_t random_probe();
    probe_t p;
    p.sx = $urandom; p.sy = $urandom; p.sz = $urandom;
    p.ex = $urandom; p.ey = $urandom; p.ez = $urandom;
    p.cx = $urandom; p.cy = $urandom; p.cz = $urandom;
    p.wx = size_t'($urandom); p.wy = size_t'($urandom); p.wz = size_t'($urandom);
    return p;
  endfunction

  // mostly pairs aimed at each other at a random scale, so that hits and
  // misses both come often; small scales sit where the epsilon decides
  function automatic probe_t make_probe();
    probe_t p;
    coord_t st[3], en[3], co[3];
    size_t  sz[3];
    longint base, w, sp, ep;
    int     mode, k;
    mode = $urandom_range(0, 9);
    if (mode == 0) return random_probe();
    k = $urandom_range(1, 29);
    for (int i = 0; i < 3; i++) begin
      base = ($urandom_range(0, 3) == 0) ? (longint'(int'($urandom)) >>> 2) : spread(k);
      w = ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom_range(0, 32'd1 << k));
      // the block adds the offset, so aim the corner before it
      co[i] = clamp_coord(base + spread(k) - w / 2 - offset_shadow[i]);
      sz[i] = size_t'(w);
      sp = base + spread(k + 1);
      if (mode == 1) ep = sp;                 // degenerate segment, a point
      else if (mode == 2) ep = 2 * base - sp; // mirrored through the aim point
      else ep = base + spread(k + 1);
      st[i] = clamp_coord(sp);
      en[i] = clamp_coord(ep);
    end
    p.sx = st[0]; p.sy = st[1]; p.sz = st[2];
    p.ex = en[0]; p.ey = en[1]; p.ez = en[2];
    p.cx = co[0]; p.cy = co[1]; p.cz = co[2];
    p.wx = sz[0]; p.wy = sz[1]; p.wz = sz[2];
    return p;
  endfunction

  task automatic put_fields(input probe_t p);
    seg_start_x  <= p.sx; seg_start_y  <= p.sy; seg_start_z  <= p.sz;
    seg_end_x    <= p.ex; seg_end_y    <= p.ey; seg_end_z    <= p.ez;
    box_corner_x <= p.cx; box_corner_y <= p.cy; box_corner_z <= p.cz;
    box_size_x   <= p.wx; box_size_y   <= p.wy; box_size_z   <= p.wz;
  endtask

  // one transaction; start stays high if the next one follows directly
  task automatic send_probe(input probe_t p);
    if (!steady) begin
      while ($urandom_range(0, 99) < 37) begin
        start <= 1'b0;
        put_fields(random_probe());   // junk on the bus while idle
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    put_fields(p);
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sent++;
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // setup and access cycle, then the bus is released
  task automatic apb_read(input logic [1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // write, then read back so the checker sees the register value
  task automatic apb_write(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (idx != REG_SPARE) offset_shadow[idx] = longint'(signed'(value));
    apb_read(idx);
  endtask

  // offset settings: zero, small, both extremes each way, full random, smaller
  task automatic set_offsets(input int setting);
    longint v[3];
    case (setting)
      0: v = '{0, 0, 0};
      1: v = '{spread(20), spread(20), spread(20)};
      2: v = '{COORD_MAX, COORD_MIN, COORD_MAX};
      3: v = '{COORD_MIN, COORD_MAX, COORD_MIN};
      4: v = '{longint'(int'($urandom)), longint'(int'($urandom)), longint'(int'($urandom))};
      default: v = '{spread(12), spread(12), spread(12)};
    endcase
    apb_write(REG_OFFSET_X, DATA_BITS'(v[0]));
    apb_write(REG_OFFSET_Y, DATA_BITS'(v[1]));
    apb_write(REG_OFFSET_Z, DATA_BITS'(v[2]));
  endtask

  // unit box at the origin unless said otherwise, offsets still at reset
  task automatic run_directed();
    // points inside, outside the upper x, y and z faces, on the far corner and one lsb past a face
    send_probe(probe_of(HALF, HALF, HALF, HALF, HALF, HALF, 0, 0, 0, ONE, ONE, ONE));
    send_probe(probe_of(ONE + HALF, HALF, HALF, ONE + HALF, HALF, HALF,
                        0, 0, 0, ONE, ONE, ONE));
    send_probe(probe_of(HALF, ONE + HALF, HALF, HALF, ONE + HALF, HALF,
                        0, 0, 0, ONE, ONE, ONE));
    send_probe(probe_of(HALF, HALF, ONE + HALF, HALF, HALF, ONE + HALF,
                        0, 0, 0, ONE, ONE, ONE));
    send_probe(probe_of(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE));
    send_probe(probe_of(ONE + 1, HALF, HALF, ONE + 1, HALF, HALF, 0, 0, 0, ONE, ONE, ONE));
    // point box: one segment through it, one a lsb to the side
    send_probe(probe_of(-ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_probe(probe_of(-ONE, 1, 0, ONE, 1, 0, 0, 0, 0, 0, 0, 0));
    // diagonals that only a cross axis can separate, plus one that cuts a corner
    send_probe(probe_of(PAST_DIAG, 0, HALF, 0, PAST_DIAG, HALF, 0, 0, 0, ONE, ONE, ONE));
    send_probe(probe_of(NEAR_DIAG, 0, HALF, 0, NEAR_DIAG, HALF, 0, 0, 0, ONE, ONE, ONE));
    send_probe(probe_of(PAST_DIAG, HALF, 0, 0, HALF, PAST_DIAG, 0, 0, 0, ONE, ONE, ONE));
    send_probe(probe_of(HALF, PAST_DIAG, 0, HALF, 0, PAST_DIAG, 0, 0, 0, ONE, ONE, ONE));
    // field extremes
    send_probe(probe_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX));
    send_probe(probe_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
    send_probe(probe_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, SIZE_MAX));
    send_probe(probe_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX));
    send_probe(probe_of(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
                        COORD_MAX, COORD_MIN, COORD_MIN, SIZE_MAX, 0, 0));
    send_probe(probe_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                        0, 0, 0, ONE, ONE, ONE));
    // short sloped segment a lsb off a face, and one grazing an edge
    send_probe(probe_of(ONE + 1, HALF, HALF, ONE + 2, HALF + 1, HALF,
                        0, 0, 0, ONE, ONE, ONE));
    send_probe(probe_of(-ONE, ONE, ONE, 2 * ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE));
  endtask

  initial begin
    offset_shadow = '{0, 0, 0};
    sent   = 0;
    steady = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers come out of reset at zero
    apb_read(REG_OFFSET_X);
    apb_read(REG_OFFSET_Y);
    apb_read(REG_OFFSET_Z);

    run_directed();

    // a write to the unused index must leave the offsets alone
    drain();
    apb_write(REG_SPARE, '1);
    apb_read(REG_OFFSET_X);
    apb_read(REG_OFFSET_Y);
    apb_read(REG_OFFSET_Z);

    // random transactions under each offset setting; offsets only change
    // once the pipeline is empty, and one setting runs back to back
    for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
      drain();
      set_offsets(setting);
      steady = (setting == 3);
      repeat (PHASE_PROBES) send_probe(make_probe());
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk_i);

    $display("%m: %0d transactions sent, %0d results checked, %0d of them overlapping",
             sent, results, touches);
    $display("%m: directed corner cases, then random pairs under %0d offset settings",
             NUM_SETTINGS);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_segment_box_overlap_test_unit: done, clean");
    end else begin
      $display("tb_segment_box_overlap_test_unit: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sbox_pkg.sv
rtl/core/sbox_prep.sv
rtl/core/sbox_axis.sv
rtl/core/sbox_cross.sv
rtl/core/segment_box_overlap_test_unit.sv
sim/sbox_overlap_checker.sv
sim/tb_segment_box_overlap_test_unit.sv
